// File: src/asn1_time_string_encoder_core_defines.svh
// Assertion macros for the BER time-string encoder.
// Sampled on the rising edge of clock, switched off while reset is high.
`ifndef ASN1_TIME_STRING_ENCODER_CORE_DEFINES_SVH
`define ASN1_TIME_STRING_ENCODER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define ASN1TSE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold from the cycle after the antecedent
`define ASN1TSE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/asn1tse_pkg.sv
// Shared types, characters and arithmetic helpers for the BER time-string encoder.
// No dependencies; used by asn1_time_string_encoder_core and by asn1tse_element_checker.
package asn1tse_pkg;

   // Output sequencer, one segment of the element per state
   typedef enum logic [14:0] {
      S_IDLE = 15'b000000000000001,
      S_TAG  = 15'b000000000000010,
      S_LEN  = 15'b000000000000100,
      S_YHI  = 15'b000000000001000,
      S_YLO  = 15'b000000000010000,
      S_MON  = 15'b000000000100000,
      S_DAY  = 15'b000000001000000,
      S_HOUR = 15'b000000010000000,
      S_MIN  = 15'b000000100000000,
      S_SEC  = 15'b000001000000000,
      S_DOT  = 15'b000010000000000,
      S_FRAC = 15'b000100000000000,
      S_SIGN = 15'b001000000000000,
      S_OFFH = 15'b010000000000000,
      S_OFFM = 15'b100000000000000
   } seq_state_type;

   // ASCII characters of the content
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_Z     = 8'h5A;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   // Input limits
   localparam logic [29:0] FRACTION_MAX = 30'd999999999;
   localparam logic [13:0] YEAR_WRAP    = 14'd10000;

   // Reciprocals for constant division (value * RECIP >> shift)
   localparam logic [7:0]  RECIP_10  = 8'd205;   // shift 11, exact below 1029
   localparam logic [12:0] RECIP_100 = 13'd5243; // shift 19, exact below 10000
   localparam logic [12:0] RECIP_60  = 13'd4370; // shift 18, exact up to 2048

   // Power of ten table, 10^0 to 10^9
   function automatic logic [29:0] pow10(input logic [3:0] k);
      logic [29:0] p;
      case (k)
         4'd0:    p = 30'd1;
         4'd1:    p = 30'd10;
         4'd2:    p = 30'd100;
         4'd3:    p = 30'd1000;
         4'd4:    p = 30'd10000;
         4'd5:    p = 30'd100000;
         4'd6:    p = 30'd1000000;
         4'd7:    p = 30'd10000000;
         4'd8:    p = 30'd100000000;
         4'd9:    p = 30'd1000000000;
         default: p = 30'd0;
      endcase
      return p;
   endfunction

   // Tens digit of a value below 100
   function automatic logic [3:0] tens_of(input logic [6:0] v);
      logic [14:0] p;
      p = {8'b0, v} * {7'b0, RECIP_10};
      return p[14:11];
   endfunction

endpackage

// File: src/asn1_time_string_encoder_core.sv
// BER UTCTime / GeneralizedTime element encoder, top level.
// Depends on asn1tse_pkg and asn1_time_string_encoder_core_defines.svh.
// After start is taken, the identifier byte passes the state register, then the output byte register.
// Throughput: one byte per cycle; an element is 12 to 31 bytes, set by the
// output sequencer, and the next start is taken in the cycle of the final byte.
// Reset clears the sequencer and the strobe; the receiver cannot stall.
`include "asn1_time_string_encoder_core_defines.svh"

module asn1_time_string_encoder_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_op,
   input  logic [7:0]         req_tag_byte,
   input  logic [13:0]        req_year,
   input  logic [3:0]         req_month,
   input  logic [4:0]         req_day,
   input  logic [4:0]         req_hour,
   input  logic [5:0]         req_minute,
   input  logic [5:0]         req_second,
   input  logic [29:0]        req_fraction,
   input  logic signed [11:0] req_offset_minutes,
   input  logic               req_utc_flag,
   output logic               rsp_valid,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_last
);

   // Sequencer and result registers
   asn1tse_pkg::seq_state_type state_ff, state_in;
   logic        digit_ff, digit_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [7:0]  rsp_out_byte_ff, rsp_out_byte_in;

   // Item registers
   logic        gen_ff;
   logic [7:0]  tag_ff;
   logic [13:0] yy_ff, yy_in;
   logic [3:0]  month_ff;
   logic [4:0]  day_ff;
   logic [4:0]  hour_ff;
   logic [5:0]  minute_ff;
   logic [5:0]  second_ff;
   logic [29:0] frac_ff, frac_in;
   logic [3:0]  fexp_ff, fexp_in;
   logic [11:0] offabs_ff, offabs_in;
   logic        neg_ff;
   logic        has_min_ff, has_min_in;
   logic        has_sec_ff, has_sec_in;
   logic        has_frac_ff, has_frac_in;
   logic        has_off_ff, has_off_in;
   logic        has_sign_ff, has_sign_in;
   logic [4:0]  len_ff, len_in;
   logic [6:0]  yhi_ff, yhi_in;
   logic [6:0]  ylo_ff, ylo_in;
   logic [5:0]  offh_ff, offh_in;
   logic [5:0]  offm_ff, offm_in;

   // Datapath and sequencer helpers
   logic        accept;
   logic [3:0]  nd;
   logic [29:0] frac_sat;
   logic [26:0] yprod;
   logic [24:0] oprod;
   logic [29:0] pw;
   logic [29:0] bound;
   logic [29:0] frac_sub;
   logic [3:0]  frac_digit;
   logic [6:0]  two_val;
   logic [3:0]  two_tens;
   logic [3:0]  two_ones;
   logic [7:0]  two_char;
   logic        is_two;
   logic        seg_done;
   logic        last_now;
   asn1tse_pkg::seq_state_type target;
   asn1tse_pkg::seq_state_type post_frac, post_sec, post_min, post_hour;

   assign accept = start && !busy;

   // Prepare the incoming item: wrap year, fold offset, count fraction digits
   always_comb begin
      yy_in = (req_year >= asn1tse_pkg::YEAR_WRAP) ?
              (req_year - asn1tse_pkg::YEAR_WRAP) : req_year;
      offabs_in = req_offset_minutes[11] ? (12'd0 - $unsigned(req_offset_minutes))
                                         : $unsigned(req_offset_minutes);
      frac_sat = (req_fraction > asn1tse_pkg::FRACTION_MAX) ?
                 asn1tse_pkg::FRACTION_MAX : req_fraction;
      nd = 4'd0;
      for (int k = 0; k < 9; k++) begin
         nd = nd + {3'b0, (req_fraction >= asn1tse_pkg::pow10(4'(k)))};
      end
      has_min_in  = !req_op || (req_minute != 6'd0) || (req_second != 6'd0);
      has_sec_in  = (req_second != 6'd0);
      has_frac_in = req_op && (req_fraction != 30'd0);
      has_off_in  = (req_offset_minutes != 12'sd0);
      has_sign_in = has_off_in || !req_op || req_utc_flag;
      len_in = (req_op ? 5'd4 : 5'd2) + 5'd6
             + (has_min_in ? 5'd2 : 5'd0)
             + (has_sec_in ? 5'd2 : 5'd0)
             + (has_frac_in ? (5'd1 + {1'b0, nd}) : 5'd0)
             + (has_off_in ? 5'd5 : (has_sign_in ? 5'd1 : 5'd0));
   end

   // Split year and offset over the identifier and length cycles
   always_comb begin
      yprod   = {13'b0, yy_ff} * {14'b0, asn1tse_pkg::RECIP_100};
      oprod   = {13'b0, offabs_ff} * {12'b0, asn1tse_pkg::RECIP_60};
      yhi_in  = (state_ff == asn1tse_pkg::S_TAG) ? yprod[25:19] : yhi_ff;
      offh_in = (state_ff == asn1tse_pkg::S_TAG) ? oprod[23:18] : offh_ff;
      ylo_in  = (state_ff == asn1tse_pkg::S_LEN) ?
                7'(yy_ff - ({7'b0, yhi_ff} * 14'd100)) : ylo_ff;
      offm_in = (state_ff == asn1tse_pkg::S_LEN) ?
                6'(offabs_ff - ({6'b0, offh_ff} * 12'd60)) : offm_ff;
   end

   // Extract the leading fraction digit by comparing against multiples of 10^k
   always_comb begin
      pw = asn1tse_pkg::pow10(fexp_ff);
      frac_sub = 30'd0;
      frac_digit = 4'd0;
      bound = 30'd0;
      for (int m = 1; m < 10; m++) begin
         bound = pw * 30'(m);
         if (frac_ff >= bound) begin
            frac_sub = bound;
            frac_digit = 4'(m);
         end
      end
   end

   // Two-digit field of the current state
   always_comb begin
      case (state_ff)
         asn1tse_pkg::S_YHI:  begin two_val = yhi_ff;             is_two = 1'b1; end
         asn1tse_pkg::S_YLO:  begin two_val = ylo_ff;             is_two = 1'b1; end
         asn1tse_pkg::S_MON:  begin two_val = {3'b0, month_ff};   is_two = 1'b1; end
         asn1tse_pkg::S_DAY:  begin two_val = {2'b0, day_ff};     is_two = 1'b1; end
         asn1tse_pkg::S_HOUR: begin two_val = {2'b0, hour_ff};    is_two = 1'b1; end
         asn1tse_pkg::S_MIN:  begin two_val = {1'b0, minute_ff};  is_two = 1'b1; end
         asn1tse_pkg::S_SEC:  begin two_val = {1'b0, second_ff};  is_two = 1'b1; end
         asn1tse_pkg::S_OFFH: begin two_val = {1'b0, offh_ff};    is_two = 1'b1; end
         asn1tse_pkg::S_OFFM: begin two_val = {1'b0, offm_ff};    is_two = 1'b1; end
         default:             begin two_val = 7'd0;               is_two = 1'b0; end
      endcase
      two_tens = asn1tse_pkg::tens_of(two_val);
      two_ones = 4'(two_val - ({3'b0, two_tens} * 7'd10));
      two_char = asn1tse_pkg::CHAR_ZERO + {4'b0, (digit_ff ? two_ones : two_tens)};
   end

   // Skip absent segments
   always_comb begin
      post_frac = has_sign_ff ? asn1tse_pkg::S_SIGN : asn1tse_pkg::S_IDLE;
      post_sec  = has_frac_ff ? asn1tse_pkg::S_DOT : post_frac;
      post_min  = has_sec_ff ? asn1tse_pkg::S_SEC : post_sec;
      post_hour = has_min_ff ? asn1tse_pkg::S_MIN : post_min;
   end

   // Pick the byte of this cycle and the segment that follows
   always_comb begin
      rsp_out_byte_in = two_char;
      seg_done = digit_ff;
      target = asn1tse_pkg::S_IDLE;
      case (state_ff)
         asn1tse_pkg::S_IDLE: begin
            seg_done = 1'b0;
         end
         asn1tse_pkg::S_TAG: begin
            rsp_out_byte_in = tag_ff;
            seg_done = 1'b1;
            target = asn1tse_pkg::S_LEN;
         end
         asn1tse_pkg::S_LEN: begin
            rsp_out_byte_in = {3'b0, len_ff};
            seg_done = 1'b1;
            target = gen_ff ? asn1tse_pkg::S_YHI : asn1tse_pkg::S_YLO;
         end
         asn1tse_pkg::S_YHI:  target = asn1tse_pkg::S_YLO;
         asn1tse_pkg::S_YLO:  target = asn1tse_pkg::S_MON;
         asn1tse_pkg::S_MON:  target = asn1tse_pkg::S_DAY;
         asn1tse_pkg::S_DAY:  target = asn1tse_pkg::S_HOUR;
         asn1tse_pkg::S_HOUR: target = post_hour;
         asn1tse_pkg::S_MIN:  target = post_min;
         asn1tse_pkg::S_SEC:  target = post_sec;
         asn1tse_pkg::S_DOT: begin
            rsp_out_byte_in = asn1tse_pkg::CHAR_DOT;
            seg_done = 1'b1;
            target = asn1tse_pkg::S_FRAC;
         end
         asn1tse_pkg::S_FRAC: begin
            rsp_out_byte_in = asn1tse_pkg::CHAR_ZERO + {4'b0, frac_digit};
            seg_done = (fexp_ff == 4'd0);
            target = post_frac;
         end
         asn1tse_pkg::S_SIGN: begin
            rsp_out_byte_in = !has_off_ff ? asn1tse_pkg::CHAR_Z :
                              (neg_ff ? asn1tse_pkg::CHAR_MINUS : asn1tse_pkg::CHAR_PLUS);
            seg_done = 1'b1;
            target = has_off_ff ? asn1tse_pkg::S_OFFH : asn1tse_pkg::S_IDLE;
         end
         asn1tse_pkg::S_OFFH: target = asn1tse_pkg::S_OFFM;
         asn1tse_pkg::S_OFFM: target = asn1tse_pkg::S_IDLE;
         default: begin
            seg_done = 1'b0;
         end
      endcase
   end

   // Hold busy until the final byte; take the next word in that same cycle
   assign last_now = (state_ff != asn1tse_pkg::S_IDLE) && seg_done &&
                     (target == asn1tse_pkg::S_IDLE);
   assign busy = (state_ff != asn1tse_pkg::S_IDLE) && !last_now;

   // Advance the sequencer
   always_comb begin
      state_in = state_ff;
      if (state_ff == asn1tse_pkg::S_IDLE || last_now) begin
         state_in = accept ? asn1tse_pkg::S_TAG : asn1tse_pkg::S_IDLE;
      end else if (seg_done) begin
         state_in = target;
      end
      digit_in = is_two && !digit_ff;
      rsp_valid_in = (state_ff != asn1tse_pkg::S_IDLE);
      rsp_last_in = last_now;
   end

   // Load the fraction on accept, drop one digit per fraction cycle
   always_comb begin
      frac_in = frac_ff;
      fexp_in = fexp_ff;
      if (accept) begin
         frac_in = frac_sat;
         fexp_in = nd - 4'd1;
      end else if (state_ff == asn1tse_pkg::S_FRAC) begin
         frac_in = frac_ff - frac_sub;
         fexp_in = fexp_ff - 4'd1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= asn1tse_pkg::S_IDLE;
         digit_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         digit_ff     <= digit_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_out_byte_ff <= rsp_out_byte_in;
      frac_ff <= frac_in;
      fexp_ff <= fexp_in;
      yhi_ff  <= yhi_in;
      ylo_ff  <= ylo_in;
      offh_ff <= offh_in;
      offm_ff <= offm_in;
      if (accept) begin
         gen_ff      <= req_op;
         tag_ff      <= req_tag_byte;
         yy_ff       <= yy_in;
         month_ff    <= req_month;
         day_ff      <= req_day;
         hour_ff     <= req_hour;
         minute_ff   <= req_minute;
         second_ff   <= req_second;
         offabs_ff   <= offabs_in;
         neg_ff      <= req_offset_minutes[11];
         has_min_ff  <= has_min_in;
         has_sec_ff  <= has_sec_in;
         has_frac_ff <= has_frac_in;
         has_off_ff  <= has_off_in;
         has_sign_ff <= has_sign_in;
         len_ff      <= len_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_out_byte_ff;
   assign rsp_last     = rsp_last_ff;

   // Checks
   `ASN1TSE_ASSERT_NEXT(a_tag_first, start && !busy,
      ##1 (rsp_valid && (rsp_out_byte == $past(req_tag_byte, 2))), "identifier byte lost")
   `ASN1TSE_ASSERT_NEXT(a_free_on_last, (state_ff != asn1tse_pkg::S_IDLE) && !busy,
      rsp_valid && rsp_last, "busy dropped before the final byte")
   `ASN1TSE_ASSERT_NEXT(a_stream_gapless, state_ff != asn1tse_pkg::S_IDLE,
      rsp_valid, "gap inside an element")
   `ASN1TSE_ASSERT_NOW(a_frac_digit_range, state_ff == asn1tse_pkg::S_FRAC,
      frac_ff < asn1tse_pkg::pow10(fexp_ff + 4'd1), "fraction digit out of range")

endmodule

// File: tb/asn1tse_tb_pkg.sv
// Testbench-side types for the BER time-string encoder: the request word and encoding codes.
// No dependencies; used by the element checker and by the testbench top.
package asn1tse_tb_pkg;

   // Encoding selected by req_op
   localparam logic OP_UTC_TIME         = 1'b0;
   localparam logic OP_GENERALIZED_TIME = 1'b1;

   // One request word, field by field at the port widths
   typedef struct packed {
      logic        op;
      logic [7:0]  tag_byte;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [29:0] fraction;
      logic [11:0] offset_minutes;
      logic        utc_flag;
   } time_word_t;

endpackage

// File: tb/asn1tse_element_checker.sv
// Watches the request and response channels of the BER time-string encoder, predicts every
// octet of each element and compares. Depends on asn1tse_pkg and asn1tse_tb_pkg.
module asn1tse_element_checker
   import asn1tse_pkg::*;
   import asn1tse_tb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       busy,
   input  time_word_t req_word,
   input  logic       rsp_valid,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_last,
   output int         mismatch_count,
   output int         octets_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] octet;
      logic       last;
   } ber_octet_t;

   ber_octet_t expected_octets_q[$];
   logic [7:0] content_q[$];

   // Append one content character
   function automatic void append_content(input logic [7:0] c);
      content_q.insert(content_q.size(), c);
   endfunction

   // Queue one expected octet with its last flag
   function automatic void queue_octet(input logic [7:0] b, input logic l);
      ber_octet_t o;
      o.octet = b;
      o.last  = l;
      expected_octets_q.insert(expected_octets_q.size(), o);
   endfunction

   // Append two decimal digits; the tens digit wraps for values of 100 and up
   function automatic void push_pair(input int unsigned v);
      append_content(CHAR_ZERO + 8'((v / 10) % 10));
      append_content(CHAR_ZERO + 8'(v % 10));
   endfunction

   // Build the whole element for one word and queue its octets
   function automatic void encode_time_element(input time_word_t w);
      int unsigned yr;
      int unsigned frac;
      int unsigned off_raw;
      int unsigned off_abs;
      logic        neg;
      logic [7:0]  frac_digits[$];
      content_q.delete();

      // date and time digits
      if (w.op == OP_UTC_TIME) begin
         push_pair(w.year % 100);
      end else begin
         yr = w.year % 10000;
         push_pair(yr / 100);
         push_pair(yr % 100);
      end
      push_pair(w.month);
      push_pair(w.day);
      push_pair(w.hour);
      if (w.op == OP_UTC_TIME || w.minute != 0 || w.second != 0) begin
         push_pair(w.minute);
      end
      if (w.second != 0) begin
         push_pair(w.second);
      end

      // fraction: saturate, then digits without leading zeros
      if (w.op == OP_GENERALIZED_TIME && w.fraction != 0) begin
         frac = (w.fraction > FRACTION_MAX) ? FRACTION_MAX : w.fraction;
         append_content(CHAR_DOT);
         while (frac != 0) begin
            frac_digits.push_front(CHAR_ZERO + 8'(frac % 10));
            frac = frac / 10;
         end
         content_q = {content_q, frac_digits};
      end

      // zone: signed hhmm offset, or Z
      neg = w.offset_minutes[11];
      off_raw = w.offset_minutes;
      off_abs = neg ? 4096 - off_raw : off_raw;
      if (off_abs != 0) begin
         append_content(neg ? CHAR_MINUS : CHAR_PLUS);
         push_pair(off_abs / 60);
         push_pair(off_abs % 60);
      end else if (w.op == OP_UTC_TIME || w.utc_flag) begin
         append_content(CHAR_Z);
      end

      // identifier, short-form length, content
      queue_octet(w.tag_byte, 1'b0);
      queue_octet(8'(content_q.size()) & 8'h7F, 1'b0);
      foreach (content_q[i]) begin
         queue_octet(content_q[i], i == content_q.size() - 1);
      end
   endfunction

   // Compare each response octet with the oldest expectation, then take a new word
   always @(posedge clock) begin
      ber_octet_t exp_octet;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_octets_q.size() == 0) begin
               $display("%0t: unexpected octet: expected none, actual byte %h last %b",
                        $time, rsp_out_byte, rsp_last);
               mismatch_count++;
            end else begin
               exp_octet = expected_octets_q.pop_front();
               if (rsp_out_byte !== exp_octet.octet) begin
                  $display("%0t: out_byte mismatch: expected %h, actual %h",
                           $time, exp_octet.octet, rsp_out_byte);
                  mismatch_count++;
               end
               if (rsp_last !== exp_octet.last) begin
                  $display("%0t: last mismatch: expected %b, actual %b",
                           $time, exp_octet.last, rsp_last);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy) begin
            encode_time_element(req_word);
         end
      end
      octets_pending <= expected_octets_q.size();
   end

endmodule

// File: tb/testbench.sv
// Top of the BER time-string encoder testbench: clock, reset, request stimulus and verdict.
// Depends on asn1tse_tb_pkg, asn1tse_element_checker and asn1_time_string_encoder_core.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import asn1tse_tb_pkg::*;

   localparam int CLOCK_PERIOD   = 10;
   localparam int RANDOM_WORDS   = 180;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int TAIL_CYCLES    = 10;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   time_word_t req_word;
   logic       rsp_valid;
   logic [7:0] rsp_out_byte;
   logic       rsp_last;
   int         mismatch_count;
   int         octets_pending;
   int         idle_cycles;
   bit         gapless;

   asn1_time_string_encoder_core DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_op             (req_word.op),
      .req_tag_byte       (req_word.tag_byte),
      .req_year           (req_word.year),
      .req_month          (req_word.month),
      .req_day            (req_word.day),
      .req_hour           (req_word.hour),
      .req_minute         (req_word.minute),
      .req_second         (req_word.second),
      .req_fraction       (req_word.fraction),
      .req_offset_minutes (req_word.offset_minutes),
      .req_utc_flag       (req_word.utc_flag),
      .rsp_valid          (rsp_valid),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last           (rsp_last)
   );

   asn1tse_element_checker element_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_word       (req_word),
      .rsp_valid      (rsp_valid),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last       (rsp_last),
      .mismatch_count (mismatch_count),
      .octets_pending (octets_pending)
   );

   initial clock = 1'b0;
   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Abort when neither a word nor an octet has moved for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic time_word_t make_word(input logic op, input int tag, input int year,
                                            input int month, input int day, input int hour,
                                            input int minute, input int second,
                                            input int fraction, input int offset,
                                            input logic utc);
      time_word_t w;
      w.op             = op;
      w.tag_byte       = 8'(tag);
      w.year           = 14'(year);
      w.month          = 4'(month);
      w.day            = 5'(day);
      w.hour           = 5'(hour);
      w.minute         = 6'(minute);
      w.second         = 6'(second);
      w.fraction       = 30'(fraction);
      w.offset_minutes = 12'(offset);
      w.utc_flag       = utc;
      return w;
   endfunction

   // Mostly legal times, with zero minutes/seconds/offsets and out-of-range values mixed in
   function automatic time_word_t random_word();
      time_word_t w;
      int unsigned pick;
      w.op       = 1'($urandom_range(0, 1));
      w.tag_byte = 8'($urandom_range(0, 255));
      w.utc_flag = 1'($urandom_range(0, 1));
      w.year     = 14'(($urandom_range(0, 9) == 0) ? $urandom_range(10000, 16383)
                                                   : $urandom_range(0, 9999));
      w.month    = 4'(($urandom_range(0, 9) == 0) ? $urandom_range(13, 15)
                                                  : $urandom_range(0, 12));
      w.day      = 5'($urandom_range(0, 31));
      w.hour     = 5'(($urandom_range(0, 9) == 0) ? $urandom_range(24, 31)
                                                  : $urandom_range(0, 23));
      pick = $urandom_range(0, 9);
      w.minute   = 6'((pick < 3) ? 0 : (pick == 3) ? $urandom_range(60, 63)
                                                   : $urandom_range(1, 59));
      pick = $urandom_range(0, 9);
      w.second   = 6'((pick < 3) ? 0 : (pick == 3) ? $urandom_range(61, 63)
                                                   : $urandom_range(1, 60));
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
         w.fraction = '0;
      end else if (pick == 3) begin
         w.fraction = 30'($urandom_range(1000000000, 30'h3FFFFFFF));
      end else if (pick < 6) begin
         w.fraction = 30'($urandom_range(1, 999));
      end else begin
         w.fraction = 30'($urandom_range(1, 999999999));
      end
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
         w.offset_minutes = '0;
      end else if (pick == 3) begin
         w.offset_minutes = 12'($urandom_range(0, 4095));
      end else begin
         w.offset_minutes = 12'(int'($urandom_range(0, 2878)) - 1439);
      end
      return w;
   endfunction

   // Hold off a random number of cycles, then present the word until it is taken
   task automatic send_word(input time_word_t w);
      int gap;
      gap = gapless ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
   endtask

   // Drop start and wait until every expected octet has come out
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (octets_pending != 0);
   endtask

   initial begin
      reset    <= 1'b1;
      start    <= 1'b0;
      req_word <= '0;
      gapless  = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words: formats, omitted fields, saturation, wrap and extreme offsets
      send_word(make_word(OP_UTC_TIME, 8'h17, 2024, 6, 15, 12, 30, 45, 0, 0, 0));
      send_word(make_word(OP_GENERALIZED_TIME, 8'h18, 2024, 6, 15, 12, 30, 45, 5, 0, 1));
      send_word(make_word(OP_GENERALIZED_TIME, 8'h18, 1999, 12, 31, 23, 0, 0, 0, 0, 0));
      send_word(make_word(OP_GENERALIZED_TIME, 8'h18, 2000, 1, 1, 0, 0, 7, 0, 0, 1));
      send_word(make_word(OP_GENERALIZED_TIME, 8'h18, 2000, 1, 1, 0, 5, 0, 0, 0, 1));
      send_word(make_word(OP_UTC_TIME, 8'h17, 2099, 1, 1, 0, 0, 0, 0, 0, 0));
      send_word(make_word(OP_UTC_TIME, 8'h17, 1950, 2, 28, 8, 15, 0, 123456, 0, 1));
      send_word(make_word(OP_GENERALIZED_TIME, 8'hFF, 9999, 12, 31, 23, 59, 59,
                          999999999, -1439, 1));
      send_word(make_word(OP_GENERALIZED_TIME, 8'h00, 16383, 15, 31, 31, 63, 63,
                          30'h3FFFFFFF, -2048, 0));
      send_word(make_word(OP_UTC_TIME, 8'h00, 16383, 15, 31, 31, 63, 63,
                          30'h3FFFFFFF, 2047, 1));
      send_word(make_word(OP_GENERALIZED_TIME, 8'h18, 0, 0, 0, 0, 0, 0, 100, 1439, 0));
      send_word(make_word(OP_GENERALIZED_TIME, 8'h18, 1, 1, 1, 1, 1, 1, 1, -1, 0));
      send_word(make_word(OP_UTC_TIME, 8'h17, 0, 0, 0, 0, 0, 0, 0, 60, 0));
      send_word(make_word(OP_UTC_TIME, 8'hAA, 1987, 10, 9, 17, 42, 60, 0, -60, 0));
      send_word(make_word(OP_GENERALIZED_TIME, 8'h55, 10000, 7, 4, 9, 0, 0, 1000000, 0, 1));
      send_word(make_word(OP_GENERALIZED_TIME, 8'h18, 2024, 3, 3, 3, 3, 0, 0, -300, 0));
      send_word(make_word(OP_GENERALIZED_TIME, 8'h18, 2024, 12, 25, 20, 59, 60,
                          987654321, -2047, 1));

      // let the encoder run dry once before the random part
      drain();

      // random words, with stretches of back-to-back starts
      repeat (RANDOM_WORDS) begin
         if ($urandom_range(0, 24) == 0) begin
            gapless = !gapless;
         end
         send_word(random_word());
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+src
src/asn1tse_pkg.sv
src/asn1_time_string_encoder_core.sv
tb/asn1tse_tb_pkg.sv
tb/asn1tse_element_checker.sv
tb/testbench.sv
